### hdl/aps_pkg.sv
// Shared types and constants for the aging priority task scheduler.
package aps_pkg;

  localparam int MAX_TASKS    = 8;
  localparam int PRIO_BITS    = 8;
  localparam int IDX_W        = $clog2(MAX_TASKS);
  localparam int TASK_COUNT_W = 4;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 64;

  localparam logic [TASK_COUNT_W-1:0] TASK_COUNT_RST = 4'd5;

  localparam logic [CFG_ADDR_W-1:0] REG_TASK_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_PRIO  = 1'd1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BLOCK  = 2'd1,
    CMD_RESUME = 2'd2,
    CMD_START  = 2'd3
  } aps_cmd_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_RUNNING = 2'd3
  } aps_slot_st_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_AGE,
    OP_COMMIT,
    OP_START,
    OP_BLOCK,
    OP_RESUME
  } aps_op_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EXEC,
    FS_PICK,
    FS_DONE
  } aps_fsm_t;

  typedef struct packed {
    aps_cmd_t   cmd;
    logic [2:0] task_number;
  } aps_in_t;

  typedef struct packed {
    logic [2:0]  running_slot;
    logic [31:0] switch_count;
  } aps_out_t;

  // per-slot control from the sequencer to one cell
  typedef struct packed {
    aps_op_t op;
    logic    sel;        // addressed by block / resume
    logic    is_cur;     // slot currently running
    logic    in_range;   // slot takes part in aging and pick
    logic    take_idle;  // default pick when no slot qualifies
    logic    home;       // idle slot 0
  } aps_cell_ctl_t;

endpackage

### hdl/aging_priority_task_scheduler.sv
// Aging priority task scheduler: sequencer, config registers and the row of slot cells.
// Steps: a tick item is aged, then picked and committed, then its result is loaded into the output
// register; block, resume and start are applied, then their result is loaded.
// The one-item sequencer takes no new item until the last result is loaded, and holds it while
// the output stalls; the pick ripples through the cell row in the commit cycle.
// Reset (synchronous, rst_n low): task_count 5, base priorities 0, countdowns 0,
// slot 0 running and the others ready, switch count 0, no result pending.
module aging_priority_task_scheduler import aps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  aps_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aps_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  aps_fsm_t                 state_r, state_nxt;
  aps_cmd_t                 cmd_r;
  logic [2:0]               task_r;
  logic [IDX_W-1:0]         current_r;
  logic [31:0]              switches_r;
  logic [TASK_COUNT_W-1:0]  task_count_r;
  logic [CFG_DATA_W-1:0]    base_prio_r;
  logic                     out_valid_r;
  aps_out_t                 out_data_r;

  aps_op_t                  cell_op;
  logic                     load_out;
  logic                     accept;

  aps_cell_ctl_t            ctl     [MAX_TASKS];
  logic [PRIO_BITS-1:0]     base_w  [MAX_TASKS];
  logic                     in_rng  [MAX_TASKS];
  logic [MAX_TASKS:0]       found;
  logic [MAX_TASKS-1:0]     picked;
  logic [IDX_W-1:0]         pick_idx;

  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign found[0]  = 1'b0;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: if (in_valid) state_nxt = FS_EXEC;
      FS_EXEC: state_nxt = (cmd_r == CMD_TICK) ? FS_PICK : FS_DONE;
      FS_PICK: state_nxt = FS_DONE;
      FS_DONE: if (!out_valid_r || !out_stall) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    cell_op  = OP_HOLD;
    load_out = 1'b0;
    case (state_r)
      FS_IDLE: in_stall = 1'b0;
      FS_EXEC: begin
        case (cmd_r)
          CMD_TICK:   cell_op = OP_AGE;
          CMD_BLOCK:  cell_op = OP_BLOCK;
          CMD_RESUME: cell_op = OP_RESUME;
          CMD_START:  cell_op = OP_START;
          default:    cell_op = OP_HOLD;
        endcase
      end
      FS_PICK: cell_op = OP_COMMIT;
      FS_DONE: load_out = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_slot
      if (gi < 8) begin : g_base
        assign base_w[gi] = PRIO_BITS'(base_prio_r[8*gi +: 8]);
      end else begin : g_nobase
        assign base_w[gi] = '0;
      end

      // slots 1 .. min(task_count, MAX_TASKS)-2 age and compete
      if (gi >= 1 && gi + 2 <= MAX_TASKS) begin : g_rng
        assign in_rng[gi] = (int'(task_count_r) >= gi + 2);
      end else begin : g_norng
        assign in_rng[gi] = 1'b0;
      end

      assign ctl[gi].op        = cell_op;
      assign ctl[gi].sel       = ((int'(task_r) + 1) == gi);
      assign ctl[gi].is_cur    = (current_r == IDX_W'(gi));
      assign ctl[gi].in_range  = in_rng[gi];
      assign ctl[gi].take_idle = (gi == 0) ? ~found[MAX_TASKS] : 1'b0;
      assign ctl[gi].home      = (gi == 0);

      aps_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl[gi]),
        .base      (base_w[gi]),
        .found_in  (found[gi]),
        .found_out (found[gi+1]),
        .picked    (picked[gi])
      );
    end
  endgenerate

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (picked[i]) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FS_IDLE;
      current_r    <= '0;
      switches_r   <= '0;
      task_count_r <= TASK_COUNT_RST;
      base_prio_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_TASK_COUNT: task_count_r <= cfg_wdata[TASK_COUNT_W-1:0];
          REG_BASE_PRIO:  base_prio_r  <= cfg_wdata;
          default:        ;
        endcase
      end

      if (cell_op == OP_COMMIT) begin
        current_r  <= pick_idx;
        switches_r <= switches_r + 32'd1;
      end else if (cell_op == OP_START) begin
        current_r <= '0;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.cmd;
      task_r <= in_data.task_number;
    end
    if (load_out) begin
      out_data_r.running_slot <= 3'(current_r);
      out_data_r.switch_count <= switches_r;
    end
  end

endmodule

### hdl/aps_cell.sv
// One scheduler slot: countdown, slot state and a link of the pick chain.
module aps_cell import aps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aps_cell_ctl_t        ctl,
  input  logic [PRIO_BITS-1:0] base,
  input  logic                 found_in,
  output logic                 found_out,
  output logic                 picked
);

  logic [PRIO_BITS-1:0] cd_r, cd_nxt;
  aps_slot_st_t         st_r, st_nxt;
  logic                 hit;

  assign hit       = ctl.in_range && (st_r == ST_READY) && (cd_r == '0);
  assign found_out = found_in | hit;
  // first qualifying slot down the chain wins
  assign picked    = (hit & ~found_in) | ctl.take_idle;

  always_comb begin
    cd_nxt = cd_r;
    st_nxt = st_r;
    case (ctl.op)
      OP_AGE: begin
        if (ctl.in_range && (st_r == ST_READY) && (cd_r != '0)) begin
          cd_nxt = cd_r - 1'b1;
        end
      end
      OP_COMMIT: begin
        if (ctl.is_cur) begin
          cd_nxt = base;
          if (st_r != ST_BLOCKED) begin
            st_nxt = ST_READY;
          end
        end
        if (picked) begin
          st_nxt = ST_RUNNING;
        end
      end
      OP_START: begin
        cd_nxt = base;
        st_nxt = ctl.home ? ST_RUNNING : ST_READY;
      end
      OP_BLOCK: begin
        if (ctl.sel) begin
          st_nxt = ST_BLOCKED;
        end
      end
      OP_RESUME: begin
        if (ctl.sel) begin
          st_nxt = ST_READY;
        end
      end
      default: begin
        cd_nxt = cd_r;
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= '0;
      st_r <= ctl.home ? ST_RUNNING : ST_READY;
    end else begin
      cd_r <= cd_nxt;
      st_r <= st_nxt;
    end
  end

endmodule

### sim/aps_checker.sv
// Scoreboard for the aging priority task scheduler: predicts each result and compares it.
module aps_checker import aps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  aps_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  aps_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TASK_COUNT_W-1:0] task_count;
  logic [CFG_DATA_W-1:0]   base_prio;
  logic [PRIO_BITS-1:0]    countdown [MAX_TASKS];
  aps_slot_st_t            slot_st [MAX_TASKS];
  logic [IDX_W-1:0]        run_slot;
  logic [31:0]             switch_total;

  aps_out_t    sched_q [$];
  int unsigned fails;

  function automatic logic [PRIO_BITS-1:0] base_of(int s);
    return (s >= 8) ? '0 : base_prio[8*s +: PRIO_BITS];
  endfunction

  // Advances the scheduler state by one command and returns the slot/switch report.
  function automatic aps_out_t schedule_step(aps_in_t it);
    int n;
    int pick;
    int tgt;
    aps_out_t res;
    tgt = int'(it.task_number) + 1;
    case (it.cmd)
      CMD_TICK: begin
        n = (task_count > MAX_TASKS) ? MAX_TASKS : int'(task_count);
        pick = 0;
        for (int i = 1; i + 1 < n; i++) begin
          if (slot_st[i] == ST_READY && countdown[i] != 0)
            countdown[i] = countdown[i] - 1'b1;
          if (pick == 0 && countdown[i] == 0 && slot_st[i] == ST_READY)
            pick = i;
        end
        // outgoing task reloads; a blocked one stays blocked
        countdown[run_slot] = base_of(int'(run_slot));
        if (slot_st[run_slot] != ST_BLOCKED)
          slot_st[run_slot] = ST_READY;
        run_slot = pick[IDX_W-1:0];
        slot_st[pick] = ST_RUNNING;
        switch_total = switch_total + 1;
      end
      CMD_BLOCK: begin
        if (tgt < MAX_TASKS)
          slot_st[tgt] = ST_BLOCKED;
      end
      CMD_RESUME: begin
        if (tgt < MAX_TASKS)
          slot_st[tgt] = ST_READY;
      end
      default: begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          countdown[i] = base_of(i);
          slot_st[i] = ST_READY;
        end
        slot_st[0] = ST_RUNNING;
        run_slot = '0;
      end
    endcase
    res.running_slot = run_slot;
    res.switch_count = switch_total;
    return res;
  endfunction

  always @(posedge clk) begin
    aps_out_t want;
    if (!rst_n) begin
      task_count = TASK_COUNT_RST;
      base_prio = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        countdown[i] = '0;
        slot_st[i] = ST_READY;
      end
      slot_st[0] = ST_RUNNING;
      run_slot = '0;
      switch_total = '0;
      sched_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_TASK_COUNT)
          task_count = cfg_wdata[TASK_COUNT_W-1:0];
        else if (cfg_addr == REG_BASE_PRIO)
          base_prio = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (sched_q.size() == 0) begin
          $error("unexpected item: running_slot %0d switch_count %0d",
                 out_data.running_slot, out_data.switch_count);
          fails++;
        end else begin
          want = sched_q.pop_front();
          if (out_data.running_slot !== want.running_slot) begin
            $error("running_slot: expected %0d, got %0d",
                   want.running_slot, out_data.running_slot);
            fails++;
          end
          if (out_data.switch_count !== want.switch_count) begin
            $error("switch_count: expected %0d, got %0d",
                   want.switch_count, out_data.switch_count);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        sched_q.push_back(schedule_step(in_data));
    end
    pending <= sched_q.size();
    fail_count <= fails;
  end

endmodule

### sim/tb.sv
// Top-level bench for the aging priority task scheduler: stimulus, config writes and verdict.
module tb import aps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT       = 300000;
  localparam int SEG_ITEMS   = 120;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  aps_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  aps_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles;
  int          in_idle_pct;
  int          out_stall_pct;

  aging_priority_task_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  aps_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(aps_cmd_t c, logic [2:0] tn);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.cmd <= c;
    in_data.task_number <= tn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      send_item(CMD_TICK, 3'($urandom_range(7)));
    else if (r < 76)
      send_item(CMD_BLOCK, 3'($urandom_range(7)));
    else if (r < 94)
      send_item(CMD_RESUME, 3'($urandom_range(7)));
    else
      send_item(CMD_START, 3'($urandom_range(7)));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] bp;
    logic [TASK_COUNT_W-1:0] tc;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_idle_pct = 12;
    out_stall_pct = 68;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: block the running task, resume the running task
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_BLOCK, 3'd0);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_RESUME, 3'd0);
    send_item(CMD_RESUME, 3'd1);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_START, 3'd0);

    // oversized task count, slot beyond the array, top user slot
    write_reg(REG_BASE_PRIO, 64'h0102_0304_FF00_0201);
    write_reg(REG_TASK_COUNT, 4'd15);
    send_item(CMD_START, 3'd7);
    send_item(CMD_BLOCK, 3'd7);
    send_item(CMD_RESUME, 3'd7);
    send_item(CMD_BLOCK, 3'd6);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_RESUME, 3'd6);
    send_item(CMD_TICK, 3'd0);

    // too few slots to age anything, then task count 3 with only slot 1 aging
    write_reg(REG_TASK_COUNT, 4'd0);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_TICK, 3'd0);
    write_reg(REG_TASK_COUNT, 4'd2);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_BLOCK, 3'd0);
    write_reg(REG_TASK_COUNT, 4'd3);
    send_item(CMD_START, 3'd0);
    send_item(CMD_TICK, 3'd0);
    send_item(CMD_TICK, 3'd0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 12;
          out_stall_pct = 68;
        end
        1: begin
          in_idle_pct = 68;
          out_stall_pct = 12;
        end
        default: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        case (3 * ph + seg)
          1: bp = '1;
          4: bp = '0;
          2, 7: bp = {$urandom, $urandom};
          default: begin
            // small bases so countdowns expire often
            for (int i = 0; i < 8; i++)
              bp[8*i +: 8] = 8'($urandom_range(3));
          end
        endcase
        case (3 * ph + seg)
          0, 4: tc = 4'd8;
          1: tc = 4'd15;
          3: tc = 4'd0;
          default: tc = 4'($urandom_range(15));
        endcase
        write_reg(REG_BASE_PRIO, bp);
        write_reg(REG_TASK_COUNT, tc);
        send_item(CMD_START, 3'($urandom_range(7)));
        repeat (SEG_ITEMS) send_random();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
hdl/aps_pkg.sv
hdl/aps_cell.sv
hdl/aging_priority_task_scheduler.sv
sim/aps_checker.sv
sim/tb.sv
